// ===== design/nsrs_pkg.sv =====
// Package with shared types and constants of the next shell radius search.
package nsrs_pkg;

  localparam logic [1:0] KIND_LATTICE = 2'd0;
  localparam logic [1:0] KIND_ATOM    = 2'd1;
  localparam logic [1:0] KIND_SEARCH  = 2'd2;

  localparam logic [1:0] CFG_ATOM_COUNT  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_GAP_EPSILON = 2'd2;

  localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_PAIR  = 6'b000100,
    ST_SQRT  = 6'b001000,
    ST_NEXT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

endpackage

// ===== design/next_shell_radius_search_top.sv =====
// Top level of the next shell radius search: lattice store, basis memory and search sequencer.
// A load word gives no result. A search reads the basis words, forms the distance and steps on
// for each ordered atom pair of each image, with image offsets -m..m on each non-zero lattice
// axis for image limit m, plus a bit-serial square root per new best candidate. busy is high
// meanwhile. Reset clears registers and the lattice; the basis memory is not cleared.
module next_shell_radius_search_top #(
  parameter int MaxAtoms  = 64,
  parameter int MaxImages = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  row_i,
  input  logic [1:0]  column_i,
  input  logic signed [31:0] coord_value_i,
  input  logic [30:0] prior_radius_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic [30:0] next_radius_o,
  output logic        found_o
);

  localparam int AW    = (MaxAtoms > 1) ? $clog2(MaxAtoms) : 1;
  localparam int CW    = $clog2(MaxAtoms + 1);
  localparam int Depth = 4 * MaxAtoms;
  localparam int MW    = $clog2(Depth);
  localparam int IW    = $clog2(MaxImages + 1) + 1;

  logic [6:0] atom_count_q;
  logic [3:0] image_limit_q;
  logic [9:0] gap_epsilon_q;
  logic signed [31:0] lat_q [3][3];

  nsrs_pkg::state_e state_q;
  logic [AW-1:0] a_q, b_q;
  logic signed [IW-1:0] j_q, k_q, l_q, jn_q, kn_q, ln_q;
  logic [CW-1:0] n_q;
  logic signed [31:0] pa_q [3];
  logic signed [31:0] pb_q [3];
  logic [63:0] lo2_q, best2_q, s_q;
  logic [31:0] root_q;
  logic [5:0] step_q;
  logic found_q;
  logic [30:0] best_q;

  logic accept, busy_w;
  assign busy_w = (state_q != nsrs_pkg::ST_IDLE);
  assign busy   = busy_w;
  assign accept = start && !busy_w;

  // Basis memory: atom a, component c at address 4*a + c.
  logic ram_we;
  logic [MW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;
  assign ram_we = accept && kind_i == nsrs_pkg::KIND_ATOM && column_i != 2'd3
                  && int'(row_i) < MaxAtoms;
  assign ram_waddr = MW'({row_i, column_i});

  nsrs_ram #(.Width(32), .Depth(Depth)) u_basis (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(coord_value_i),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // Six reads per pair: a_x..a_z, then b_x..b_z. rc_q walks 0..6; data lands in the cycle
  // after its address.
  logic [2:0] rc_q;
  always_comb begin
    ram_raddr = '0;
    if (rc_q < 3'd3) ram_raddr = MW'({a_q, rc_q[1:0]});
    else             ram_raddr = MW'({b_q, 2'(rc_q - 3'd3)});
  end

  // Distance of the current pair and image. The image offset is registered while the basis
  // words are read, and the clamped components at the first distance cycle.
  logic signed [40:0] t [3];
  logic signed [40:0] t_q [3];
  logic signed [41:0] d [3];
  logic [31:0] m [3];
  logic [31:0] m_q [3];
  logic [63:0] sq;
  logic [63:0] s_w;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t[c] = 41'(j_q * lat_q[0][c]) + 41'(k_q * lat_q[1][c]) + 41'(l_q * lat_q[2][c]);
      d[c] = 42'(pa_q[c]) - 42'(pb_q[c]) - 42'(t_q[c]);
      if (d[c][41]) begin
        m[c] = ((-d[c]) > 42'sh80000000) ? 32'h8000_0000 : 32'((-d[c]));
      end else begin
        m[c] = (d[c] > 42'sh80000000) ? 32'h8000_0000 : 32'(d[c]);
      end
    end
  end
  logic [1:0] sc_q;
  logic [63:0] acc_q;
  logic [31:0] msel;
  always_comb begin
    unique case (sc_q)
      2'd1:    msel = m_q[0];
      2'd2:    msel = m_q[1];
      2'd3:    msel = m_q[2];
      default: msel = '0;
    endcase
  end
  assign sq  = msel * msel;
  assign s_w = acc_q + sq;

  logic last_l, last_k, last_j, last_b, last_a, skip;
  assign last_b = (CW'(b_q) + 1'b1 == n_q);
  assign last_a = (CW'(a_q) + 1'b1 == n_q);
  assign last_l = (l_q == ln_q);
  assign last_k = (k_q == kn_q);
  assign last_j = (j_q == jn_q);
  assign skip   = (a_q == b_q) && j_q == 0 && k_q == 0 && l_q == 0;

  logic [31:0] lo_w;
  logic zero_ax [3];
  always_comb begin
    for (int r = 0; r < 3; r++) zero_ax[r] = lat_q[r][0] == 0 && lat_q[r][1] == 0
                                           && lat_q[r][2] == 0;
    lo_w = 32'(prior_radius_i) + 32'(gap_epsilon_q) + 32'd1;
  end
  logic [IW-1:0] lim_w;
  assign lim_w = (int'(image_limit_q) > MaxImages) ? IW'(MaxImages) : IW'(image_limit_q);
  logic [CW-1:0] n_w;
  assign n_w = (int'(atom_count_q) > MaxAtoms) ? CW'(MaxAtoms) : CW'(atom_count_q);

  // Bit-serial root: partial remainder pr_q, root root_q.
  logic [32:0] pr_q;
  logic [34:0] pr_sh, pr_try;
  assign pr_sh  = {pr_q, s_q[63:62]};
  assign pr_try = pr_sh - 35'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsrs_pkg::ST_IDLE;
      atom_count_q <= 7'd1;
      image_limit_q <= 4'd15;
      gap_epsilon_q <= 10'd1;
      result_valid_o <= 1'b0;
      next_radius_o <= '0;
      found_o <= 1'b0;
      for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) lat_q[r][c] <= '0;
      for (int c = 0; c < 3; c++) begin
        pa_q[c] <= '0;
        pb_q[c] <= '0;
        t_q[c]  <= '0;
        m_q[c]  <= '0;
      end
      a_q <= '0;
      b_q <= '0;
      j_q <= '0;
      k_q <= '0;
      l_q <= '0;
      jn_q <= '0;
      kn_q <= '0;
      ln_q <= '0;
      n_q <= '0;
      rc_q <= '0;
      sc_q <= '0;
      acc_q <= '0;
      lo2_q <= '0;
      best2_q <= '0;
      s_q <= '0;
      pr_q <= '0;
      root_q <= '0;
      step_q <= '0;
      found_q <= 1'b0;
      best_q <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          nsrs_pkg::CFG_ATOM_COUNT:  atom_count_q  <= cfg_wdata_i[6:0];
          nsrs_pkg::CFG_IMAGE_LIMIT: image_limit_q <= cfg_wdata_i[3:0];
          nsrs_pkg::CFG_GAP_EPSILON: gap_epsilon_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (state_q)
        nsrs_pkg::ST_IDLE: begin
          if (accept && kind_i == nsrs_pkg::KIND_LATTICE && row_i < 6'd3
              && column_i != 2'd3) begin
            lat_q[row_i[1:0]][column_i] <= coord_value_i;
          end
          if (accept && kind_i == nsrs_pkg::KIND_SEARCH) begin
            found_q <= 1'b0;
            best_q  <= '0;
            lo2_q   <= lo_w * lo_w;
            n_q     <= n_w;
            jn_q <= zero_ax[0] ? '0 : lim_w;
            kn_q <= zero_ax[1] ? '0 : lim_w;
            ln_q <= zero_ax[2] ? '0 : lim_w;
            j_q  <= zero_ax[0] ? '0 : -lim_w;
            k_q  <= zero_ax[1] ? '0 : -lim_w;
            l_q  <= zero_ax[2] ? '0 : -lim_w;
            a_q <= '0;
            b_q <= '0;
            rc_q <= '0;
            if (lo_w > 32'(nsrs_pkg::RADIUS_MAX) || n_w == '0) state_q <= nsrs_pkg::ST_DONE;
            else state_q <= nsrs_pkg::ST_READ;
          end
        end
        nsrs_pkg::ST_READ: begin
          for (int c = 0; c < 3; c++) t_q[c] <= t[c];
          // Data for address rc-1 arrives now.
          if (rc_q != 3'd0) begin
            if (rc_q <= 3'd3) pa_q[2'(rc_q - 3'd1)] <= ram_rdata;
            else pb_q[2'(rc_q - 3'd4)] <= ram_rdata;
          end
          if (rc_q == 3'd6) begin
            state_q <= nsrs_pkg::ST_PAIR;
            sc_q <= '0;
            acc_q <= '0;
          end else begin
            rc_q <= rc_q + 3'd1;
          end
        end
        nsrs_pkg::ST_PAIR: begin
          if (sc_q == 2'd0) begin
            for (int c = 0; c < 3; c++) m_q[c] <= m[c];
          end else begin
            acc_q <= s_w;
          end
          if (sc_q == 2'd3) begin
            if (!skip && s_w >= lo2_q && (!found_q || s_w < best2_q)) begin
              s_q <= s_w;
              pr_q <= '0;
              root_q <= '0;
              step_q <= '0;
              state_q <= nsrs_pkg::ST_SQRT;
            end else begin
              state_q <= nsrs_pkg::ST_NEXT;
            end
          end else begin
            sc_q <= sc_q + 2'd1;
          end
        end
        nsrs_pkg::ST_SQRT: begin
          s_q <= {s_q[61:0], 2'b00};
          if (!pr_try[34]) begin
            pr_q <= pr_try[32:0];
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            pr_q <= pr_sh[32:0];
            root_q <= {root_q[30:0], 1'b0};
          end
          step_q <= step_q + 6'd1;
          if (step_q == 6'd31) state_q <= nsrs_pkg::ST_NEXT;
        end
        nsrs_pkg::ST_NEXT: begin
          if (step_q == 6'd32) begin
            // A new best was just rooted.
            found_q <= 1'b1;
            best_q  <= root_q[31] ? nsrs_pkg::RADIUS_MAX : root_q[30:0];
            best2_q <= root_q[31] ? 64'(nsrs_pkg::RADIUS_MAX) * 64'(nsrs_pkg::RADIUS_MAX)
                                  : root_q * root_q;
          end
          step_q <= '0;
          rc_q <= '0;
          state_q <= nsrs_pkg::ST_READ;
          if (!last_b) b_q <= b_q + 1'b1;
          else begin
            b_q <= '0;
            if (!last_a) a_q <= a_q + 1'b1;
            else begin
              a_q <= '0;
              if (!last_l) l_q <= l_q + 1'b1;
              else begin
                l_q <= -ln_q;
                if (!last_k) k_q <= k_q + 1'b1;
                else begin
                  k_q <= -kn_q;
                  if (!last_j) j_q <= j_q + 1'b1;
                  else state_q <= nsrs_pkg::ST_DONE;
                end
              end
            end
          end
        end
        nsrs_pkg::ST_DONE: begin
          result_valid_o <= 1'b1;
          next_radius_o <= found_q ? best_q : '0;
          found_o <= found_q;
          state_q <= nsrs_pkg::ST_IDLE;
        end
        default: state_q <= nsrs_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/nsrs_ram.sv =====
// Generic RAM with one write port, one read port and registered read data.
module nsrs_ram #(
  parameter int Width = 32,
  parameter int Depth = 192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
